>>> rtl/core/gcd_pkg.sv
// Shared types, constants and the arc-tangent table for the great-circle distance core.
`timescale 1ns / 1ps
package gcd_pkg;

  // Number of micro-rotations in every CORDIC pipeline.
  localparam int unsigned CORDIC_STEPS = 30;

  // CORDIC gain compensation, Q30.
  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

  // One right angle as a Q30 phase.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QUEUE_AW    = 4;

  // The four phases that one beat needs, binary angles with 2^32 per turn.
  typedef struct packed {
    logic [31:0] lat_a;
    logic [31:0] lat_b;
    logic [31:0] half_dlat;
    logic [31:0] half_dlon;
  } phase_set_t;

  // atan(2^-idx) as a binary phase.
  function automatic logic signed [32:0] arc_step(input int unsigned idx);
    logic signed [32:0] val;
    case (idx)
      0:       val = 33'sd536870912;
      1:       val = 33'sd316933406;
      2:       val = 33'sd167458907;
      3:       val = 33'sd85004756;
      4:       val = 33'sd42667331;
      5:       val = 33'sd21354465;
      6:       val = 33'sd10679838;
      7:       val = 33'sd5340245;
      8:       val = 33'sd2670163;
      9:       val = 33'sd1335087;
      10:      val = 33'sd667544;
      11:      val = 33'sd333772;
      12:      val = 33'sd166886;
      13:      val = 33'sd83443;
      14:      val = 33'sd41722;
      15:      val = 33'sd20861;
      16:      val = 33'sd10430;
      17:      val = 33'sd5215;
      18:      val = 33'sd2608;
      19:      val = 33'sd1304;
      20:      val = 33'sd652;
      21:      val = 33'sd326;
      22:      val = 33'sd163;
      23:      val = 33'sd81;
      24:      val = 33'sd41;
      25:      val = 33'sd20;
      26:      val = 33'sd10;
      27:      val = 33'sd5;
      28:      val = 33'sd3;
      29:      val = 33'sd1;
      default: val = 33'sd0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/gcd_front.sv
// Front part: accepts beats, converts degrees to binary phases and manages queue credits.
`timescale 1ns / 1ps
module gcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [27:0] in_first_latitude,
  input  logic signed [28:0] in_first_longitude,
  input  logic signed [27:0] in_second_latitude,
  input  logic signed [28:0] in_second_longitude,
  input  logic               credit_ret,
  output logic               ph_vld,
  output gcd_pkg::phase_set_t ph_data
);
  import gcd_pkg::*;

  localparam int unsigned NUM_W    = 39;
  localparam int unsigned PIPE_LEN = 4;
  localparam logic [NUM_W-1:0] HALF_DIV = NUM_W'(45);
  // ceil(2^45 / 90); (num * RECIP) >> 45 equals num / 90 for every num below 2^39.
  localparam logic [38:0] RECIP = 39'd390937467654;

  logic                  accept;
  logic [QUEUE_AW:0]     cred_r, cred_nxt;

  logic signed [27:0]    lat_a_r, lat_b_r;
  logic signed [28:0]    lon_a_r, lon_b_r;
  logic                  in_vld_r;

  logic [NUM_W-1:0]      num_r   [0:3];
  logic [37:0]           pp_hh_r [0:3];
  logic [38:0]           pp_hl_r [0:3];
  logic [38:0]           pp_lh_r [0:3];
  logic [39:0]           pp_ll_r [0:3];
  logic [37:0]           hh_r    [0:3];
  logic [40:0]           mid_r   [0:3];
  logic [57:0]           prod_sh [0:3];
  logic [31:0]           quo_r   [0:3];
  logic [3:0]            neg_r   [0:PIPE_LEN-1];
  logic [PIPE_LEN-1:0]   vld_r;

  logic signed [28:0]    dlat;
  logic signed [29:0]    dlon;
  logic [29:0]           mag [0:3];
  logic [3:0]            sgn;

  logic                  out_vld_r;
  phase_set_t            out_data_r;

  assign accept = start && !busy;
  assign busy   = (cred_r == '0);

  // Credits count free queue slots not yet claimed by beats in flight.
  always_comb begin
    cred_nxt = cred_r;
    if (accept && !credit_ret) begin
      cred_nxt = cred_r - 1'b1;
    end else if (!accept && credit_ret) begin
      cred_nxt = cred_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r    <= (QUEUE_AW+1)'(QUEUE_DEPTH);
      in_vld_r  <= 1'b0;
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cred_r    <= cred_nxt;
      in_vld_r  <= accept;
      vld_r     <= {vld_r[PIPE_LEN-2:0], in_vld_r};
      out_vld_r <= vld_r[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    lat_a_r <= in_first_latitude;
    lon_a_r <= in_first_longitude;
    lat_b_r <= in_second_latitude;
    lon_b_r <= in_second_longitude;
  end

  always_comb begin
    dlat   = 29'(lat_b_r) - 29'(lat_a_r);
    dlon   = 30'(lon_b_r) - 30'(lon_a_r);
    sgn    = {dlon[29], dlat[28], lat_b_r[27], lat_a_r[27]};
    mag[0] = lat_a_r[27] ? 30'(-30'(lat_a_r)) : 30'(lat_a_r);
    mag[1] = lat_b_r[27] ? 30'(-30'(lat_b_r)) : 30'(lat_b_r);
    mag[2] = dlat[28] ? 30'(-30'(dlat)) : 30'(dlat);
    mag[3] = dlon[29] ? 30'(-dlon) : 30'(dlon);
  end

  // Phase = round(deg * 4096 / 360) for full angles, with 2048 for half
  // differences; both reduce to floor((mag * 2^k + 45) / 90).
  always_ff @(posedge clk) begin
    num_r[0] <= {mag[0][28:0], 10'b0} + HALF_DIV;
    num_r[1] <= {mag[1][28:0], 10'b0} + HALF_DIV;
    num_r[2] <= {mag[2], 9'b0} + HALF_DIV;
    num_r[3] <= {mag[3], 9'b0} + HALF_DIV;
    neg_r[0] <= sgn;
  end

  // Division by 90 as a multiplication by its reciprocal, split at bit 20 into
  // four partial products that are summed in the hh_r/mid_r and quo_r registers.
  // Only the product shifted right by 20 is kept, which is exact for the floor.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod_sh[c] = {hh_r[c], 20'b0} + 58'(mid_r[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      pp_hh_r[c] <= 38'(num_r[c][38:20]) * 38'(RECIP[38:20]);
      pp_hl_r[c] <= 39'(num_r[c][38:20]) * 39'(RECIP[19:0]);
      pp_lh_r[c] <= 39'(num_r[c][19:0]) * 39'(RECIP[38:20]);
      pp_ll_r[c] <= 40'(num_r[c][19:0]) * 40'(RECIP[19:0]);
      hh_r[c]    <= pp_hh_r[c];
      mid_r[c]   <= 41'(pp_hl_r[c]) + 41'(pp_lh_r[c]) + 41'(pp_ll_r[c][39:20]);
      quo_r[c]   <= prod_sh[c][56:25];
    end
    for (int s = 1; s < PIPE_LEN; s++) begin
      neg_r[s] <= neg_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.lat_a     <= neg_r[PIPE_LEN-1][0] ? 32'(-quo_r[0]) : quo_r[0];
    out_data_r.lat_b     <= neg_r[PIPE_LEN-1][1] ? 32'(-quo_r[1]) : quo_r[1];
    out_data_r.half_dlat <= neg_r[PIPE_LEN-1][2] ? 32'(-quo_r[2]) : quo_r[2];
    out_data_r.half_dlon <= neg_r[PIPE_LEN-1][3] ? 32'(-quo_r[3]) : quo_r[3];
  end

  assign ph_vld  = out_vld_r;
  assign ph_data = out_data_r;

endmodule

>>> rtl/core/gcd_queue.sv
// Short queue of phase sets between the front and back parts.
`timescale 1ns / 1ps
module gcd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gcd_pkg::phase_set_t push_data,
  output logic                pop_vld,
  output gcd_pkg::phase_set_t pop_data
);
  import gcd_pkg::*;

  phase_set_t          mem_r [0:QUEUE_DEPTH-1];
  logic [QUEUE_AW-1:0] wr_r, rd_r;
  logic [QUEUE_AW:0]   cnt_r;

  // The back part never stalls, so the head leaves whenever it exists.
  assign pop_vld  = (cnt_r != '0);
  assign pop_data = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop_vld) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop_vld) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop_vld) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/gcd_rotate.sv
// Pipelined CORDIC rotation giving the sine or cosine of a binary phase in Q30.
`timescale 1ns / 1ps
module gcd_rotate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [31:0]         in_phase,
  input  logic                pick_sin,
  output logic                out_vld,
  output logic signed [32:0]  out_val
);
  import gcd_pkg::*;

  logic [CORDIC_STEPS+1:0] vld_r;
  logic signed [32:0]      x_r [0:CORDIC_STEPS];
  logic signed [32:0]      y_r [0:CORDIC_STEPS];
  logic signed [32:0]      z_r [0:CORDIC_STEPS];
  logic [1:0]              quad_r [0:CORDIC_STEPS];
  logic [31:0]             shifted;
  logic [31:0]             rest;
  logic signed [32:0]      out_val_r;

  // Fold the phase to within an eighth turn of the nearest quarter turn.
  assign shifted = in_phase + 32'h2000_0000;
  assign rest    = in_phase - {shifted[31:30], 30'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CORDIC_STEPS:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]    <= GAIN_Q30;
    y_r[0]    <= '0;
    z_r[0]    <= {rest[31], rest};
    quad_r[0] <= shifted[31:30];
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
    logic signed [32:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!z_r[i][32]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
        z_r[i+1] <= z_r[i] - arc_step(i);
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
        z_r[i+1] <= z_r[i] + arc_step(i);
      end
      quad_r[i+1] <= quad_r[i];
    end
  end

  always_ff @(posedge clk) begin
    case (quad_r[CORDIC_STEPS])
      2'd0:    out_val_r <= pick_sin ? y_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
      2'd1:    out_val_r <= pick_sin ? x_r[CORDIC_STEPS] : -y_r[CORDIC_STEPS];
      2'd2:    out_val_r <= pick_sin ? -y_r[CORDIC_STEPS] : -x_r[CORDIC_STEPS];
      default: out_val_r <= pick_sin ? -x_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
    endcase
  end

  assign out_vld = vld_r[CORDIC_STEPS+1];
  assign out_val = out_val_r;

endmodule

>>> rtl/core/gcd_back.sv
// Back part: trigonometry, haversine term, square roots, atan2 and scaling to kilometres.
`timescale 1ns / 1ps
module gcd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  gcd_pkg::phase_set_t q_data,
  output logic                out_valid,
  output logic [22:0]         out_distance
);
  import gcd_pkg::*;

  localparam int unsigned SQ_STEPS = 31;
  localparam int unsigned TAIL     = 3 + SQ_STEPS + CORDIC_STEPS + 3;
  localparam logic [16:0] K_HI     = 17'd80060;
  localparam logic [15:0] K_LO     = 16'd22753;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0080_0000_0000;

  logic [3:0]              rot_vld;
  logic signed [32:0]      c_a, c_b, s_dl, s_dn;
  logic [TAIL-1:0]         vld_r;

  logic signed [65:0]      sdl_sq, sdn_sq, cc_p, t_p;
  logic signed [32:0]      sq_lat_r, sq_lon_r, cc_r, sq_lat2_r;
  logic signed [33:0]      t_r, a_sum;
  logic [30:0]             a_r;

  logic [60:0]             sv_in   [0:SQ_STEPS-1][0:1];
  logic [61:0]             sres_in [0:SQ_STEPS-1][0:1];
  logic [60:0]             sv_r    [0:SQ_STEPS-1][0:1];
  logic [61:0]             sres_r  [0:SQ_STEPS-1][0:1];

  logic signed [33:0]      vx_in [0:CORDIC_STEPS-1];
  logic signed [33:0]      vy_in [0:CORDIC_STEPS-1];
  logic signed [32:0]      vz_in [0:CORDIC_STEPS-1];
  logic signed [33:0]      vx_r  [0:CORDIC_STEPS-1];
  logic signed [33:0]      vy_r  [0:CORDIC_STEPS-1];
  logic signed [32:0]      vz_r  [0:CORDIC_STEPS-1];

  logic [30:0]             zc_r;
  logic [47:0]             p_hi_r;
  logic [46:0]             p_lo_r;
  logic [63:0]             total;
  logic [22:0]             dist_r;

  gcd_rotate u_rot_lat_a (.clk, .rst_n, .in_vld(q_vld), .in_phase(q_data.lat_a),
                          .pick_sin(1'b0), .out_vld(rot_vld[0]), .out_val(c_a));
  gcd_rotate u_rot_lat_b (.clk, .rst_n, .in_vld(q_vld), .in_phase(q_data.lat_b),
                          .pick_sin(1'b0), .out_vld(rot_vld[1]), .out_val(c_b));
  gcd_rotate u_rot_dlat  (.clk, .rst_n, .in_vld(q_vld), .in_phase(q_data.half_dlat),
                          .pick_sin(1'b1), .out_vld(rot_vld[2]), .out_val(s_dl));
  gcd_rotate u_rot_dlon  (.clk, .rst_n, .in_vld(q_vld), .in_phase(q_data.half_dlon),
                          .pick_sin(1'b1), .out_vld(rot_vld[3]), .out_val(s_dn));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[TAIL-2:0], &rot_vld};
    end
  end

  // Squares, cosine product, then the weighted longitude term.
  assign sdl_sq = s_dl * s_dl;
  assign sdn_sq = s_dn * s_dn;
  assign cc_p   = c_a * c_b;
  assign t_p    = cc_r * sq_lon_r;
  assign a_sum  = {sq_lat2_r[32], sq_lat2_r} + t_r;

  always_ff @(posedge clk) begin
    sq_lat_r  <= sdl_sq[62:30];
    sq_lon_r  <= sdn_sq[62:30];
    cc_r      <= cc_p[62:30];
    sq_lat2_r <= sq_lat_r;
    t_r       <= t_p[63:30];
    if (a_sum[33]) begin
      a_r <= '0;
    end else if (a_sum > 34'(ONE_Q30)) begin
      a_r <= ONE_Q30;
    end else begin
      a_r <= a_sum[30:0];
    end
  end

  // Bitwise square roots of a and 1-a, both scaled by 2^30.
  assign sv_in[0][0]   = {a_r, 30'b0};
  assign sv_in[0][1]   = {31'(ONE_Q30 - a_r), 30'b0};
  assign sres_in[0][0] = '0;
  assign sres_in[0][1] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [61:0] BITV = 62'(1) << (60 - 2*k);
    if (k > 0) begin : g_link
      for (genvar c = 0; c < 2; c++) begin : g_c
        assign sv_in[k][c]   = sv_r[k-1][c];
        assign sres_in[k][c] = sres_r[k-1][c];
      end
    end
    for (genvar c = 0; c < 2; c++) begin : g_ch
      logic [61:0] trial;
      assign trial = sres_in[k][c] + BITV;
      always_ff @(posedge clk) begin
        if ({1'b0, sv_in[k][c]} >= trial) begin
          sv_r[k][c]   <= sv_in[k][c] - trial[60:0];
          sres_r[k][c] <= (sres_in[k][c] >> 1) + BITV;
        end else begin
          sv_r[k][c]   <= sv_in[k][c];
          sres_r[k][c] <= sres_in[k][c] >> 1;
        end
      end
    end
  end

  // CORDIC vectoring on (sqrt(1-a), sqrt(a)) gives the half central angle.
  assign vx_in[0] = 34'(sres_r[SQ_STEPS-1][1][30:0]);
  assign vy_in[0] = 34'(sres_r[SQ_STEPS-1][0][30:0]);
  assign vz_in[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [33:0] dx, dy;
    if (i > 0) begin : g_link
      assign vx_in[i] = vx_r[i-1];
      assign vy_in[i] = vy_r[i-1];
      assign vz_in[i] = vz_r[i-1];
    end
    assign dx = vy_in[i] >>> i;
    assign dy = vx_in[i] >>> i;
    always_ff @(posedge clk) begin
      if (!vy_in[i][33]) begin
        vx_r[i] <= vx_in[i] + dx;
        vy_r[i] <= vy_in[i] - dy;
        vz_r[i] <= vz_in[i] + arc_step(i);
      end else begin
        vx_r[i] <= vx_in[i] - dx;
        vy_r[i] <= vy_in[i] + dy;
        vz_r[i] <= vz_in[i] - arc_step(i);
      end
    end
  end

  // Clamp to a quarter turn, then scale by 4*pi*R*2^16 in two partial products.
  assign total = {p_hi_r, 16'b0} + 64'(p_lo_r) + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (vz_r[CORDIC_STEPS-1][32]) begin
      zc_r <= '0;
    end else if (vz_r[CORDIC_STEPS-1] > 33'(ONE_Q30)) begin
      zc_r <= ONE_Q30;
    end else begin
      zc_r <= vz_r[CORDIC_STEPS-1][30:0];
    end
    p_hi_r <= 48'(zc_r) * 48'(K_HI);
    p_lo_r <= 47'(zc_r) * 47'(K_LO);
    dist_r <= total[62:40];
  end

  assign out_valid    = vld_r[TAIL-1];
  assign out_distance = dist_r;

endmodule

>>> rtl/core/great_circle_distance_core.sv
// Top level of the pipelined haversine great-circle distance core.
//
//   Channel   Ports                                    Handshake
//   input     in_first_/second_latitude/longitude      start high and busy low
//   result    out_distance                              out_valid, one cycle
//
// The core takes one beat per clock when busy is low; each distance passes
// through the phase conversion, the queue, one 30-step CORDIC rotation, the
// haversine term, the 31-step square root, the 30-step CORDIC vectoring and
// the scaling in series.
// Reset is synchronous and active low; it empties the pipelines and queue.
// The result side cannot stall: out_valid is a one-cycle strobe.
// busy rises only when all queue credits are claimed by beats in flight,
// which the back part drains at one beat per clock.
`timescale 1ns / 1ps
module great_circle_distance_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [27:0] in_first_latitude,
  input  logic signed [28:0] in_first_longitude,
  input  logic signed [27:0] in_second_latitude,
  input  logic signed [28:0] in_second_longitude,
  output logic               out_valid,
  output logic [22:0]        out_distance
);
  import gcd_pkg::*;

  logic       ph_vld;
  phase_set_t ph_data;
  logic       q_vld;
  phase_set_t q_data;

  // The front part converts the coordinates to four binary phases. It
  // holds a credit for each queue slot, so a beat is never accepted
  // unless its phases are sure to find room in the queue.
  gcd_front u_front (
    .clk,
    .rst_n,
    .start,
    .busy,
    .in_first_latitude,
    .in_first_longitude,
    .in_second_latitude,
    .in_second_longitude,
    .credit_ret (q_vld),
    .ph_vld,
    .ph_data
  );

  // The queue decouples the two parts; a credit comes back each time a
  // phase set leaves it.
  gcd_queue u_queue (
    .clk,
    .rst_n,
    .push      (ph_vld),
    .push_data (ph_data),
    .pop_vld   (q_vld),
    .pop_data  (q_data)
  );

  // The back part is a free-running pipeline that computes the haversine
  // term, its square roots, the atan2 and the final scaling.
  gcd_back u_back (
    .clk,
    .rst_n,
    .q_vld,
    .q_data,
    .out_valid,
    .out_distance
  );

endmodule
